// ===== rtl/core/rti_pkg.sv =====
// Package for the ray / triangle intersection pipeline: types, widths and register codes.
`default_nettype none

package rti_pkg;

  localparam int CoordBits = 16;
  localparam int CoordW    = (CoordBits < 16) ? CoordBits : 16;
  localparam int SxSh      = 16 - CoordW;

  localparam int DivSteps  = 31;
  localparam int FracBits  = 16;
  localparam int FrontStg  = 7;
  localparam int NStg      = FrontStg + DivSteps + 1;

  localparam int DetW      = 53;
  localparam int RemW      = 54;
  localparam int NloW      = DivSteps - FracBits;

  typedef enum logic [2:0] {
    CfgOrgX = 3'd0,
    CfgOrgY = 3'd1,
    CfgOrgZ = 3'd2,
    CfgDirX = 3'd3,
    CfgDirY = 3'd4,
    CfgDirZ = 3'd5,
    CfgEps  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] vert0_x;
    logic signed [15:0] vert0_y;
    logic signed [15:0] vert0_z;
    logic signed [15:0] vert1_x;
    logic signed [15:0] vert1_y;
    logic signed [15:0] vert1_z;
    logic signed [15:0] vert2_x;
    logic signed [15:0] vert2_y;
    logic signed [15:0] vert2_z;
  } tri_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] hit_distance;
    logic        [16:0] bary_u;
    logic        [16:0] bary_v;
  } tri_out_t;

  typedef struct packed {
    logic [RemW-1:0]     r;
    logic [NloW-1:0]     nlo;
    logic [DivSteps-1:0] q;
  } div_lane_t;

  typedef struct packed {
    logic [DetW-1:0] det;
    logic            hit;
    logic            dneg;
    logic            dsat;
    div_lane_t [2:0] lane;
  } div_stage_t;

endpackage

`default_nettype wire

// ===== rtl/core/ray_triangle_intersect.sv =====
// Throughput: one triangle per cycle while in_stall_o is low; 7 arithmetic
// stages feed a 31-stage restoring divider that produces one quotient bit per
// stage for u, v and t.
// Bubbles collapse; a stalled output holds the pipe only once it is full.
// Reset clears all valid bits and loads the ray and epsilon registers with defaults.
`default_nettype none

module ray_triangle_intersect
  import rti_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire tri_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output tri_out_t      out_data_o,
  input  wire logic     cfg_valid_i,
  output logic          cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);

  localparam int EW = 17;
  localparam int PPW = 33;
  localparam int QPW = 34;
  localparam int PVW = 34;
  localparam int QVW = 35;
  localparam int MW = 52;
  localparam int SW = 54;

  function automatic logic signed [15:0] sx(input logic [15:0] x);
    logic signed [15:0] t;
    t = $signed(x << SxSh);
    return t >>> SxSh;
  endfunction

  function automatic div_lane_t div_step(input div_lane_t l, input logic [DetW-1:0] det);
    div_lane_t       o;
    logic [RemW-1:0] r2;
    logic            qb;
    r2 = {l.r[RemW-2:0], l.nlo[NloW-1]};
    qb = (r2 >= {1'b0, det});
    o.r   = qb ? (r2 - {1'b0, det}) : r2;
    o.nlo = {l.nlo[NloW-2:0], 1'b0};
    o.q   = {l.q[DivSteps-2:0], qb};
    return o;
  endfunction

  logic [15:0] org_x_q, org_y_q, org_z_q, dir_x_q, dir_y_q, dir_z_q;
  logic [23:0] eps_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      dir_x_q <= 16'd256;
      dir_y_q <= '0;
      dir_z_q <= '0;
      eps_q   <= 24'd1678;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgOrgX: org_x_q <= cfg_data_i[15:0];
        CfgOrgY: org_y_q <= cfg_data_i[15:0];
        CfgOrgZ: org_z_q <= cfg_data_i[15:0];
        CfgDirX: dir_x_q <= cfg_data_i[15:0];
        CfgDirY: dir_y_q <= cfg_data_i[15:0];
        CfgDirZ: dir_z_q <= cfg_data_i[15:0];
        CfgEps:  eps_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [15:0] org [3];
  logic signed [15:0] dir [3];
  logic signed [15:0] p0 [3];
  logic signed [15:0] p1 [3];
  logic signed [15:0] p2 [3];

  always_comb begin
    org[0] = sx(org_x_q);
    org[1] = sx(org_y_q);
    org[2] = sx(org_z_q);
    dir[0] = sx(dir_x_q);
    dir[1] = sx(dir_y_q);
    dir[2] = sx(dir_z_q);
    p0[0] = sx(in_data_i.vert0_x);
    p0[1] = sx(in_data_i.vert0_y);
    p0[2] = sx(in_data_i.vert0_z);
    p1[0] = sx(in_data_i.vert1_x);
    p1[1] = sx(in_data_i.vert1_y);
    p1[2] = sx(in_data_i.vert1_z);
    p2[0] = sx(in_data_i.vert2_x);
    p2[1] = sx(in_data_i.vert2_y);
    p2[2] = sx(in_data_i.vert2_z);
  end

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] ld;

  always_comb begin
    for (int k = 0; k < NStg; k++) begin
      ld[k] = !out_stall_i || !(&(v_q | NStg'((64'd1 << k) - 64'd1)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (ld[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign in_stall_o  = !ld[0];
  assign out_valid_o = v_q[NStg-1];

  logic signed [EW-1:0] a_e1_q [3];
  logic signed [EW-1:0] a_e2_q [3];
  logic signed [EW-1:0] a_t0_q [3];

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      for (int i = 0; i < 3; i++) begin
        a_e1_q[i] <= {p1[i][15], p1[i]} - {p0[i][15], p0[i]};
        a_e2_q[i] <= {p2[i][15], p2[i]} - {p0[i][15], p0[i]};
        a_t0_q[i] <= {org[i][15], org[i]} - {p0[i][15], p0[i]};
      end
    end
  end

  logic signed [PPW-1:0] b_pp_q [6];
  logic signed [QPW-1:0] b_qp_q [6];
  logic signed [EW-1:0]  b_e1_q [3];
  logic signed [EW-1:0]  b_e2_q [3];
  logic signed [EW-1:0]  b_t0_q [3];

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      b_pp_q[0] <= dir[1] * a_e2_q[2];
      b_pp_q[1] <= dir[2] * a_e2_q[1];
      b_pp_q[2] <= dir[2] * a_e2_q[0];
      b_pp_q[3] <= dir[0] * a_e2_q[2];
      b_pp_q[4] <= dir[0] * a_e2_q[1];
      b_pp_q[5] <= dir[1] * a_e2_q[0];
      b_qp_q[0] <= a_t0_q[1] * a_e1_q[2];
      b_qp_q[1] <= a_t0_q[2] * a_e1_q[1];
      b_qp_q[2] <= a_t0_q[2] * a_e1_q[0];
      b_qp_q[3] <= a_t0_q[0] * a_e1_q[2];
      b_qp_q[4] <= a_t0_q[0] * a_e1_q[1];
      b_qp_q[5] <= a_t0_q[1] * a_e1_q[0];
      b_e1_q <= a_e1_q;
      b_e2_q <= a_e2_q;
      b_t0_q <= a_t0_q;
    end
  end

  logic signed [PVW-1:0] c_pv_q [3];
  logic signed [QVW-1:0] c_qv_q [3];
  logic signed [EW-1:0]  c_e1_q [3];
  logic signed [EW-1:0]  c_e2_q [3];
  logic signed [EW-1:0]  c_t0_q [3];

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      for (int i = 0; i < 3; i++) begin
        c_pv_q[i] <= PVW'(b_pp_q[2*i]) - PVW'(b_pp_q[2*i+1]);
        c_qv_q[i] <= QVW'(b_qp_q[2*i]) - QVW'(b_qp_q[2*i+1]);
      end
      c_e1_q <= b_e1_q;
      c_e2_q <= b_e2_q;
      c_t0_q <= b_t0_q;
    end
  end

  logic signed [MW-1:0] d_de_q [3];
  logic signed [MW-1:0] d_du_q [3];
  logic signed [MW-1:0] d_dv_q [3];
  logic signed [MW-1:0] d_dd_q [3];

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      for (int i = 0; i < 3; i++) begin
        d_de_q[i] <= c_e1_q[i] * c_pv_q[i];
        d_du_q[i] <= c_t0_q[i] * c_pv_q[i];
        d_dv_q[i] <= dir[i] * c_qv_q[i];
        d_dd_q[i] <= c_e2_q[i] * c_qv_q[i];
      end
    end
  end

  logic signed [SW-1:0] e_det_q, e_u_q, e_v_q, e_d_q;

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      e_det_q <= SW'(d_de_q[0]) + SW'(d_de_q[1]) + SW'(d_de_q[2]);
      e_u_q   <= SW'(d_du_q[0]) + SW'(d_du_q[1]) + SW'(d_du_q[2]);
      e_v_q   <= SW'(d_dv_q[0]) + SW'(d_dv_q[1]) + SW'(d_dv_q[2]);
      e_d_q   <= SW'(d_dd_q[0]) + SW'(d_dd_q[1]) + SW'(d_dd_q[2]);
    end
  end

  logic signed [SW-1:0] f_det_q, f_u_q, f_v_q, f_d_q;
  logic                 e_pos;

  assign e_pos = (e_det_q > 0);

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      f_det_q <= e_pos ? e_det_q : -e_det_q;
      f_u_q   <= e_pos ? e_u_q : -e_u_q;
      f_v_q   <= e_pos ? e_v_q : -e_v_q;
      f_d_q   <= e_pos ? e_d_q : -e_d_q;
    end
  end

  div_stage_t           dv_q [DivSteps+1];
  div_stage_t           g_d;
  logic signed [SW:0]   f_uv;
  logic        [SW-1:0] f_nd;
  logic        [SW-1:0] f_nu;
  logic        [SW-1:0] f_nv;

  always_comb begin
    f_uv = (SW+1)'(f_u_q) + (SW+1)'(f_v_q);
    f_nd = (f_d_q < 0) ? $unsigned(-f_d_q) : $unsigned(f_d_q);
    f_nu = $unsigned(f_u_q);
    f_nv = $unsigned(f_v_q);
    g_d.det  = f_det_q[DetW-1:0];
    g_d.hit  = !((f_det_q == 0) || ($unsigned(f_det_q) < SW'(eps_q)) ||
                 (f_u_q < 0) || (f_u_q > f_det_q) ||
                 (f_v_q < 0) || (f_uv > (SW+1)'(f_det_q)));
    g_d.dneg = (f_d_q < 0);
    g_d.dsat = ((f_nd >> NloW) >= SW'(f_det_q[DetW-1:0]));
    g_d.lane[0].r   = f_nu >> NloW;
    g_d.lane[0].nlo = f_nu[NloW-1:0];
    g_d.lane[0].q   = '0;
    g_d.lane[1].r   = f_nv >> NloW;
    g_d.lane[1].nlo = f_nv[NloW-1:0];
    g_d.lane[1].q   = '0;
    g_d.lane[2].r   = f_nd >> NloW;
    g_d.lane[2].nlo = f_nd[NloW-1:0];
    g_d.lane[2].q   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      dv_q[0] <= g_d;
    end
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (ld[FrontStg+j]) begin
        dv_q[j+1].det  <= dv_q[j].det;
        dv_q[j+1].hit  <= dv_q[j].hit;
        dv_q[j+1].dneg <= dv_q[j].dneg;
        dv_q[j+1].dsat <= dv_q[j].dsat;
        for (int l = 0; l < 3; l++) begin
          dv_q[j+1].lane[l] <= div_step(dv_q[j].lane[l], dv_q[j].det);
        end
      end
    end
  end

  div_stage_t  dl;
  tri_out_t    o_d;
  tri_out_t    out_q;
  logic [31:0] dmag;

  always_comb begin
    dl   = dv_q[DivSteps];
    dmag = {1'b0, dl.lane[2].q};
    o_d.hit = dl.hit;
    if (!dl.hit) begin
      o_d.hit_distance = '0;
      o_d.bary_u       = '0;
      o_d.bary_v       = '0;
    end else begin
      o_d.bary_u = dl.lane[0].q[16:0];
      o_d.bary_v = dl.lane[1].q[16:0];
      if (dl.dsat) begin
        o_d.hit_distance = dl.dneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        o_d.hit_distance = dl.dneg ? $signed(-dmag) : $signed(dmag);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[NStg-1]) begin
      out_q <= o_d;
    end
  end

  assign out_data_o = out_q;

`ifndef SYNTH
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |->
      out_data_o.hit_distance == 0 && out_data_o.bary_u == 0 && out_data_o.bary_v == 0)
    else $error("miss result carries nonzero fields");

  a_bary_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |->
      ({1'b0, out_data_o.bary_u} + {1'b0, out_data_o.bary_v}) <= 18'h10000)
    else $error("barycentric sum above one");

  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&v_q) |-> !in_stall_o)
    else $error("input stalled while pipeline has a bubble");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NStg-2] && dv_q[DivSteps].hit && !dv_q[DivSteps].dsat |->
      dv_q[DivSteps].lane[2].r < {1'b0, dv_q[DivSteps].det})
    else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire
